// File: rtl/bpa_pkg.sv
// Shared types, constants and a helper function of the buddy page allocator.
package bpa_pkg;

  // Fixed field widths.
  localparam int ADDR_W    = 48;
  localparam int FUNC_W    = 2;
  localparam int RANK_W    = 5;
  localparam int VAL_W     = 11;
  localparam int STAT_W    = 2;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 1;
  localparam int WORD_W    = 64;

  // Widest page index and page count over the legal parameter range.
  localparam int PG_W = 15;
  localparam int PC_W = 16;
  // Width for buddy arithmetic that may step past the pool end.
  localparam int XW   = 17;

  // Parameter defaults.
  localparam int DEF_MAX_PAGES  = 1024;
  localparam int DEF_TOP_RANK   = 16;
  localparam int DEF_PAGE_BYTES = 4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC  = 2'd0,
    FN_FREE   = 2'd1,
    FN_QRANK  = 2'd2,
    FN_QCOUNT = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_NOSPACE = 2'd2
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_BUILD, S_BOP_RD, S_BOP_WR, S_EXEC,
    S_A_FIND, S_A_SCAN, S_A_CHK, S_A_SPLIT,
    S_F_CHK, S_F_LOOP, S_F_BCHK, S_F_MERGE,
    S_Q_RD, S_Q_CHK, S_RESP
  } state_t;

  // One entry of the page store: head rank and allocated mark.
  typedef struct packed {
    logic              alloc;
    logic [RANK_W-1:0] rank;
  } pm_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              in_load;
    logic              rebuild_ack;
    logic              sweep;
    logic              pm_re;
    logic [PG_W-1:0]   pm_raddr;
    logic              pm_we;
    logic [PG_W-1:0]   pm_waddr;
    pm_entry_t         pm_wdata;
    logic              bm_re;
    logic              bm_we;
    logic [RANK_W-1:0] bm_rank;
    logic [PG_W-1:0]   bm_page;
    logic [WORD_W-1:0] bm_wdata;
    logic              cnt_clr;
    logic              cnt_inc;
    logic              cnt_dec;
    logic [RANK_W-1:0] cnt_rank;
    logic [PG_W-1:0]   res_page;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              rebuild_req;
    logic              pool_ok;
    logic              page_ok;
    logic [PG_W-1:0]   page_idx;
    logic [PC_W-1:0]   page_count;
    pm_entry_t         pm_q;
    logic [WORD_W-1:0] bm_q;
    logic [VAL_W-1:0]  cnt_q;
    logic [ADDR_W-1:0] blk_addr;
  } sts_t;

  // Index of the lowest set bit of a bitmap word.
  function automatic logic [5:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [5:0] n;
    n = 6'd63;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) n = 6'(i);
    end
    return n;
  endfunction

endpackage

// File: rtl/bpa_req_if.sv
// Request channel: operation code, rank and address.
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [RANK_W-1:0] req_rank;
  logic [ADDR_W-1:0] address;

  modport source (output valid, func, req_rank, address, input ready);
  modport sink   (input valid, func, req_rank, address, output ready);
endinterface

// File: rtl/bpa_rsp_if.sv
// Response channel: status, block address and value.
interface bpa_rsp_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] block_address;
  logic [VAL_W-1:0]  value;

  modport source (output valid, status, block_address, value, input ready);
  modport sink   (input valid, status, block_address, value, output ready);
endinterface

// File: rtl/bpa_dp.sv
// Datapath: configuration registers, page store, free bitmaps and free counts.
module bpa_dp import bpa_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int TOP_RANK   = DEF_TOP_RANK,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [ADDR_W-1:0]    in_address,
  input  cmd_t                 cmd,
  output sts_t                 st
);

  localparam int PW        = $clog2(MAX_PAGES);
  localparam int PCW       = $clog2(MAX_PAGES + 1);
  localparam int SH        = $clog2(PAGE_BYTES);
  localparam int MAP_WORDS = (MAX_PAGES + 63) / 64;
  localparam int BM_DEPTH  = TOP_RANK * MAP_WORDS;
  localparam int BW        = $clog2(BM_DEPTH);
  localparam int TRW       = $clog2(TOP_RANK);

  logic [ADDR_W-1:0] base_r;
  logic [PCW-1:0]    pc_r;
  logic [PCW-1:0]    pc_nxt;
  logic              pend_r;
  logic [ADDR_W-1:0] addr_r;

  pm_entry_t         pm_mem [MAX_PAGES];
  pm_entry_t         pm_q_r;
  logic [WORD_W-1:0] bm_mem [BM_DEPTH];
  logic [WORD_W-1:0] bm_q_r;
  logic [VAL_W-1:0]  cnt_r [TOP_RANK];

  logic [ADDR_W-1:0] off;
  logic [ADDR_W-1:0] off_page;
  logic              pm_we_i;
  pm_entry_t         pm_wd;
  logic [BW-1:0]     bm_map_addr;
  logic [BW-1:0]     bm_addr;
  logic              bm_we_i;
  logic [WORD_W-1:0] bm_wd;
  logic [TRW-1:0]    cnt_idx;
  logic              cnt_rank_ok;

  // Page count writes saturate at the store size.
  assign pc_nxt = (XW'(cfg_data[VAL_W-1:0]) > XW'(MAX_PAGES)) ? PCW'(MAX_PAGES)
                                                              : PCW'(cfg_data[VAL_W-1:0]);

  // Configuration registers and the rebuild request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      pc_r   <= '0;
      pend_r <= 1'b1;
    end else begin
      if (cmd.rebuild_ack) pend_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_BASE: base_r <= cfg_data[ADDR_W-1:0];
          CFG_PAGE_COUNT: begin
            pc_r   <= pc_nxt;
            pend_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Request address is held for the whole operation.
  always_ff @(posedge clk) begin
    if (cmd.in_load) addr_r <= in_address;
  end

  // Address to page translation.
  assign off      = addr_r - base_r;
  assign off_page = off >> SH;

  // Page store port: the clearing sweep writes zero.
  assign pm_we_i = cmd.pm_we | cmd.sweep;
  assign pm_wd   = cmd.sweep ? pm_entry_t'('0) : cmd.pm_wdata;

  always_ff @(posedge clk) begin
    if (pm_we_i) pm_mem[cmd.pm_waddr[PW-1:0]] <= pm_wd;
    if (cmd.pm_re) pm_q_r <= pm_mem[cmd.pm_raddr[PW-1:0]];
  end

  // Bitmap rows are laid out rank after rank, one word per 64 pages.
  assign bm_map_addr = BW'((32'(cmd.bm_rank) - 32'd1) * 32'(MAP_WORDS)
                           + 32'(cmd.bm_page[PW-1:0] >> 6));
  assign bm_addr = cmd.sweep ? BW'(cmd.pm_waddr) : bm_map_addr;
  assign bm_we_i = cmd.bm_we | (cmd.sweep && (32'(cmd.pm_waddr) < BM_DEPTH));
  assign bm_wd   = cmd.sweep ? '0 : cmd.bm_wdata;

  always_ff @(posedge clk) begin
    if (bm_we_i) bm_mem[bm_addr] <= bm_wd;
    if (cmd.bm_re) bm_q_r <= bm_mem[bm_addr];
  end

  // Free block counts, one per rank.
  assign cnt_idx     = TRW'(cmd.cnt_rank - RANK_W'(1));
  assign cnt_rank_ok = (cmd.cnt_rank != '0) && (cmd.cnt_rank <= RANK_W'(TOP_RANK));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      for (int i = 0; i < TOP_RANK; i++) cnt_r[i] <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r[cnt_idx] <= cnt_r[cnt_idx] + VAL_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r[cnt_idx] <= cnt_r[cnt_idx] - VAL_W'(1);
    end
  end

  // Status toward the controller.
  always_comb begin
    st.rebuild_req = pend_r;
    st.pool_ok     = (base_r != '0) && (pc_r != '0);
    st.page_ok     = st.pool_ok && ((off & ADDR_W'(PAGE_BYTES - 1)) == '0)
                     && (off_page < ADDR_W'(pc_r));
    st.page_idx    = PG_W'(off_page[PW-1:0]);
    st.page_count  = PC_W'(pc_r);
    st.pm_q        = pm_q_r;
    st.bm_q        = bm_q_r;
    st.cnt_q       = cnt_rank_ok ? cnt_r[cnt_idx] : '0;
    st.blk_addr    = base_r + (ADDR_W'(cmd.res_page[PW-1:0]) << SH);
  end

endmodule

// File: rtl/bpa_ctrl.sv
// Controller: sequences rebuild, allocate, free and queries over the datapath.
module bpa_ctrl import bpa_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int TOP_RANK  = DEF_TOP_RANK
) (
  input  logic       clk,
  input  logic       rst_n,
  bpa_req_if.sink    in_req,
  bpa_rsp_if.source  out_rsp,
  output cmd_t       cmd,
  input  sts_t       st
);

  localparam int PW  = $clog2(MAX_PAGES);
  localparam int PCW = $clog2(MAX_PAGES + 1);

  state_t            state_r, state_nxt;
  state_t            ret_r, ret_nxt;
  func_t             func_r, func_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [RANK_W-1:0] s_r, s_nxt;
  logic [PW-1:0]     page_r, page_nxt;
  logic [PW-1:0]     b_r, b_nxt;
  logic [PCW:0]      scan_r, scan_nxt;
  logic [PW-1:0]     clr_r, clr_nxt;
  logic [PCW-1:0]    off_r, off_nxt;
  logic [PCW-1:0]    rem_r, rem_nxt;
  logic [PW-1:0]     bop_page_r, bop_page_nxt;
  logic [RANK_W-1:0] bop_rank_r, bop_rank_nxt;
  logic              bop_set_r, bop_set_nxt;
  stat_t             res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  stat_t             out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [VAL_W-1:0]  out_value_r;

  logic [PCW-1:0]    pc;
  logic              rank_ok;
  logic [RANK_W-1:0] lg;
  logic [RANK_W-1:0] bld_rank;
  logic [PCW-1:0]    bld_size;
  logic [WORD_W-1:0] bop_bit;
  logic [XW-1:0]     fsz;
  logic [XW-1:0]     fb_x;
  logic              fb_out;
  logic [PW-1:0]     q_head;
  logic [PW-1:0]     sp_page;

  assign pc      = PCW'(st.page_count);
  assign rank_ok = (rank_r != '0) && (rank_r <= RANK_W'(TOP_RANK));

  // Rank of the next block in the pool decomposition.
  always_comb begin
    lg = '0;
    for (int i = 0; i < PCW; i++) begin
      if (rem_r[i]) lg = RANK_W'(i);
    end
    bld_rank = (lg >= RANK_W'(TOP_RANK)) ? RANK_W'(TOP_RANK) : lg + RANK_W'(1);
    bld_size = PCW'(1) << (bld_rank - RANK_W'(1));
  end

  // Buddy, head and split arithmetic.
  assign bop_bit = WORD_W'(1) << bop_page_r[5:0];
  assign fsz     = XW'(1) << (s_r - RANK_W'(1));
  assign fb_x    = XW'(page_r) ^ fsz;
  assign fb_out  = (fb_x + fsz) > XW'(pc);
  assign q_head  = page_r & ~PW'(fsz - XW'(1));
  assign sp_page = PW'(XW'(page_r) + (XW'(1) << (s_r - RANK_W'(2))));

  assign in_req.ready = (state_r == S_IDLE) && !st.rebuild_req;

  // Next state, working registers and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    func_nxt       = func_r;
    rank_nxt       = rank_r;
    s_nxt          = s_r;
    page_nxt       = page_r;
    b_nxt          = b_r;
    scan_nxt       = scan_r;
    clr_nxt        = clr_r;
    off_nxt        = off_r;
    rem_nxt        = rem_r;
    bop_page_nxt   = bop_page_r;
    bop_rank_nxt   = bop_rank_r;
    bop_set_nxt    = bop_set_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_value_nxt  = res_value_r;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    cmd            = '0;
    cmd.cnt_rank   = rank_r;
    cmd.res_page   = PG_W'(page_r);

    case (state_r)
      S_IDLE: begin
        if (st.rebuild_req) begin
          cmd.rebuild_ack = 1'b1;
          cmd.cnt_clr     = 1'b1;
          clr_nxt         = '0;
          state_nxt       = S_CLR;
        end else if (in_req.valid) begin
          cmd.in_load    = 1'b1;
          func_nxt       = func_t'(in_req.func);
          rank_nxt       = in_req.req_rank;
          res_status_nxt = STAT_OK;
          res_addr_nxt   = '0;
          res_value_nxt  = '0;
          state_nxt      = S_EXEC;
        end
      end

      // Clearing sweep over the page store and the bitmaps.
      S_CLR: begin
        cmd.sweep    = 1'b1;
        cmd.pm_waddr = PG_W'(clr_r);
        if (clr_r == PW'(MAX_PAGES - 1)) begin
          off_nxt   = '0;
          rem_nxt   = pc;
          state_nxt = S_BUILD;
        end else begin
          clr_nxt = clr_r + PW'(1);
        end
      end

      // Cut the pool into free blocks, largest first.
      S_BUILD: begin
        if (rem_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          bop_page_nxt = PW'(off_r);
          bop_rank_nxt = bld_rank;
          bop_set_nxt  = 1'b1;
          ret_nxt      = S_BUILD;
          off_nxt      = off_r + bld_size;
          rem_nxt      = rem_r - bld_size;
          state_nxt    = S_BOP_RD;
        end
      end

      // Bitmap read-modify-write with count update; a set also writes the head entry.
      S_BOP_RD: begin
        cmd.bm_re   = 1'b1;
        cmd.bm_rank = bop_rank_r;
        cmd.bm_page = PG_W'(bop_page_r);
        state_nxt   = S_BOP_WR;
      end

      S_BOP_WR: begin
        cmd.bm_we    = 1'b1;
        cmd.bm_rank  = bop_rank_r;
        cmd.bm_page  = PG_W'(bop_page_r);
        cmd.bm_wdata = bop_set_r ? (st.bm_q | bop_bit) : (st.bm_q & ~bop_bit);
        cmd.cnt_rank = bop_rank_r;
        cmd.cnt_inc  = bop_set_r;
        cmd.cnt_dec  = !bop_set_r;
        if (bop_set_r) begin
          cmd.pm_we          = 1'b1;
          cmd.pm_waddr       = PG_W'(bop_page_r);
          cmd.pm_wdata.alloc = 1'b0;
          cmd.pm_wdata.rank  = bop_rank_r;
        end
        state_nxt = ret_r;
      end

      S_EXEC: begin
        case (func_r)
          FN_ALLOC: begin
            if (!rank_ok) begin
              res_status_nxt = STAT_INVALID;
              state_nxt      = S_RESP;
            end else if (!st.pool_ok) begin
              res_status_nxt = STAT_NOSPACE;
              state_nxt      = S_RESP;
            end else begin
              s_nxt     = rank_r;
              state_nxt = S_A_FIND;
            end
          end
          FN_FREE: begin
            if (!st.page_ok) begin
              res_status_nxt = STAT_INVALID;
              state_nxt      = S_RESP;
            end else begin
              page_nxt     = PW'(st.page_idx);
              cmd.pm_re    = 1'b1;
              cmd.pm_raddr = st.page_idx;
              state_nxt    = S_F_CHK;
            end
          end
          FN_QRANK: begin
            if (!st.page_ok) begin
              res_status_nxt = STAT_INVALID;
              state_nxt      = S_RESP;
            end else begin
              page_nxt  = PW'(st.page_idx);
              s_nxt     = RANK_W'(1);
              state_nxt = S_Q_RD;
            end
          end
          FN_QCOUNT: begin
            if (!rank_ok) res_status_nxt = STAT_INVALID;
            else res_value_nxt = st.cnt_q;
            state_nxt = S_RESP;
          end
          default: state_nxt = S_RESP;
        endcase
      end

      // Smallest rank at or above the request that has a free block.
      S_A_FIND: begin
        cmd.cnt_rank = s_r;
        if (s_r > RANK_W'(TOP_RANK)) begin
          res_status_nxt = STAT_NOSPACE;
          state_nxt      = S_RESP;
        end else if (st.cnt_q == '0) begin
          s_nxt = s_r + RANK_W'(1);
        end else begin
          scan_nxt  = '0;
          state_nxt = S_A_SCAN;
        end
      end

      S_A_SCAN: begin
        if (scan_r < {1'b0, pc}) begin
          cmd.bm_re   = 1'b1;
          cmd.bm_rank = s_r;
          cmd.bm_page = PG_W'(scan_r);
          state_nxt   = S_A_CHK;
        end else begin
          res_status_nxt = STAT_NOSPACE;
          state_nxt      = S_RESP;
        end
      end

      S_A_CHK: begin
        if (st.bm_q != '0) begin
          page_nxt     = PW'(scan_r) | PW'(lowest_set(st.bm_q));
          bop_page_nxt = PW'(scan_r) | PW'(lowest_set(st.bm_q));
          bop_rank_nxt = s_r;
          bop_set_nxt  = 1'b0;
          ret_nxt      = S_A_SPLIT;
          state_nxt    = S_BOP_RD;
        end else begin
          scan_nxt  = scan_r + (PCW + 1)'(64);
          state_nxt = S_A_SCAN;
        end
      end

      // Split down, freeing each right half.
      S_A_SPLIT: begin
        if (s_r > rank_r) begin
          bop_page_nxt = sp_page;
          bop_rank_nxt = s_r - RANK_W'(1);
          bop_set_nxt  = 1'b1;
          s_nxt        = s_r - RANK_W'(1);
          ret_nxt      = S_A_SPLIT;
          state_nxt    = S_BOP_RD;
        end else begin
          cmd.pm_we          = 1'b1;
          cmd.pm_waddr       = PG_W'(page_r);
          cmd.pm_wdata.alloc = 1'b1;
          cmd.pm_wdata.rank  = rank_r;
          res_addr_nxt       = st.blk_addr;
          state_nxt          = S_RESP;
        end
      end

      S_F_CHK: begin
        if (st.pm_q.rank == '0 || st.pm_q.rank > RANK_W'(TOP_RANK) || !st.pm_q.alloc) begin
          res_status_nxt = STAT_INVALID;
          state_nxt      = S_RESP;
        end else begin
          s_nxt     = st.pm_q.rank;
          state_nxt = S_F_LOOP;
        end
      end

      // Merge with the buddy while it is a free block of equal rank.
      S_F_LOOP: begin
        if (s_r >= RANK_W'(TOP_RANK) || fb_out) begin
          bop_page_nxt = page_r;
          bop_rank_nxt = s_r;
          bop_set_nxt  = 1'b1;
          ret_nxt      = S_RESP;
          state_nxt    = S_BOP_RD;
        end else begin
          b_nxt        = PW'(fb_x);
          cmd.pm_re    = 1'b1;
          cmd.pm_raddr = PG_W'(fb_x);
          state_nxt    = S_F_BCHK;
        end
      end

      S_F_BCHK: begin
        bop_rank_nxt = s_r;
        state_nxt    = S_BOP_RD;
        if (st.pm_q.rank != s_r || st.pm_q.alloc) begin
          bop_page_nxt = page_r;
          bop_set_nxt  = 1'b1;
          ret_nxt      = S_RESP;
        end else begin
          bop_page_nxt = b_r;
          bop_set_nxt  = 1'b0;
          ret_nxt      = S_F_MERGE;
        end
      end

      // The upper half loses its head; the lower half heads the merged block.
      S_F_MERGE: begin
        cmd.pm_we    = 1'b1;
        cmd.pm_waddr = PG_W'((b_r > page_r) ? b_r : page_r);
        page_nxt     = (b_r < page_r) ? b_r : page_r;
        s_nxt        = s_r + RANK_W'(1);
        state_nxt    = S_F_LOOP;
      end

      // Look for a head of each rank that would cover the page.
      S_Q_RD: begin
        cmd.pm_re    = 1'b1;
        cmd.pm_raddr = PG_W'(q_head);
        state_nxt    = S_Q_CHK;
      end

      S_Q_CHK: begin
        if (st.pm_q.rank == s_r) begin
          res_value_nxt = VAL_W'(s_r);
          state_nxt     = S_RESP;
        end else if (s_r == RANK_W'(TOP_RANK)) begin
          res_status_nxt = STAT_INVALID;
          state_nxt      = S_RESP;
        end else begin
          s_nxt     = s_r + RANK_W'(1);
          state_nxt = S_Q_RD;
        end
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    func_r       <= func_nxt;
    rank_r       <= rank_nxt;
    s_r          <= s_nxt;
    page_r       <= page_nxt;
    b_r          <= b_nxt;
    scan_r       <= scan_nxt;
    clr_r        <= clr_nxt;
    off_r        <= off_nxt;
    rem_r        <= rem_nxt;
    bop_page_r   <= bop_page_nxt;
    bop_rank_r   <= bop_rank_nxt;
    bop_set_r    <= bop_set_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_value_r  <= res_value_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.block_address = out_addr_r;
  assign out_rsp.value         = out_value_r;

  // A bitmap update always resumes the sequence that requested it.
  a_bop_return: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BOP_WR |=> state_r == $past(ret_r))
    else $error("bitmap update did not return to its caller");

  // No request is taken while the store waits for a rebuild.
  a_no_accept_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    st.rebuild_req |-> !in_req.ready)
    else $error("request accepted with rebuild pending");

  // The clearing sweep owns both memory write ports.
  a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep |-> !cmd.pm_we && !cmd.bm_we)
    else $error("write collides with clearing sweep");

  // Bitmap updates only touch legal ranks.
  a_bop_rank: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BOP_RD |-> bop_rank_r != '0 && bop_rank_r <= RANK_W'(TOP_RANK))
    else $error("bitmap update with rank out of range");

  // A free block is only removed from a rank that has one.
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> st.cnt_q != '0)
    else $error("free count underflow");

endmodule

// File: rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator: controller and datapath.
//
//   channel   dir  handshake      payload
//   in_req    in   valid/ready    func, req_rank, address
//   out_rsp   out  valid/ready    status, block_address, value
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// One operation is in flight at a time. Allocate finds the smallest rank with a free
// block, scans its bitmap words and splits down; free merges with its buddy level by
// level; query rank tries each rank from the lowest up; count query and early rejects
// go straight to the response.
// Reset and every page count write start a rebuild: a clearing sweep of the page store
// and bitmaps, then one bitmap update per free block; no request is taken meanwhile.
// A result waits in the output register while the next request is taken.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int TOP_RANK   = DEF_TOP_RANK,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bpa_req_if.sink              in_req,
  bpa_rsp_if.source            out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t st;

  // Operation sequencer.
  bpa_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .TOP_RANK  (TOP_RANK)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cmd     (cmd),
    .st      (st)
  );

  // Storage and address arithmetic.
  bpa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .TOP_RANK   (TOP_RANK),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_address (in_req.address),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
